### rtl/core/ffa_pkg.sv
`timescale 1ns / 1ps
package ffa_pkg;
  localparam int unsigned TableEntries = 1024;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam int unsigned OutCntW = 11;
  localparam int unsigned QDepth = 2;

  typedef enum logic {
    OpAlloc   = 1'b0,
    OpRelease = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] start;
    logic [31:0] size;
  } req_t;

  typedef struct packed {
    logic [31:0]        granted;
    logic               status;
    logic [31:0]        free_total;
    logic [OutCntW-1:0] entry_count;
    logic [OutCntW-1:0] peak_entries;
    logic [31:0]        lost_count;
    logic [31:0]        lost_bytes;
  } rsp_t;

  function automatic logic [OutCntW-1:0] cnt_out(input logic [CntW-1:0] c);
    logic [OutCntW+CntW-1:0] w;
    w = {{OutCntW{1'b0}}, c};
    return w[OutCntW-1:0];
  endfunction
endpackage

### rtl/core/first_fit_free_list_allocator.sv
`timescale 1ns / 1ps
// Channel  Dir  Fields
// s_axis   in   tuser: opcode; tdata: region_start[31:0] region_size[63:32]
// m_axis   out  tdata: granted_start, status, free_total, entry_count,
//               peak_entries, lost_count, lost_bytes (low bit up)
// A front queue of two beats takes requests while the back end works.
// One table read port. Allocate reads, then checks, each scanned entry;
// an entry used up exactly is closed by shifting later ones down.
// Release scans, then merges, or shifts entries up and inserts.
// Results wait for m_tready. Reset clears counts; table unset.
module first_fit_free_list_allocator import ffa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic         s_tuser_i,   // opcode
  input  logic [63:0]  s_tdata_i,   // region_start, region_size
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [151:0] m_tdata_o    // granted_start, status, free_total,
                                    // entry_count, peak_entries,
                                    // lost_count, lost_bytes
);
  logic q_valid, q_ready;
  req_t q_req;
  rsp_t rsp;

  ffa_front u_front (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .s_tuser_i, .s_tdata_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_req_o(q_req)
  );
  ffa_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_req_i(q_req),
    .r_valid_o(m_tvalid_o), .r_ready_i(m_tready_i), .r_rsp_o(rsp)
  );

  assign m_tdata_o = {1'b0, rsp.lost_bytes, rsp.lost_count, rsp.peak_entries,
                      rsp.entry_count, rsp.free_total, rsp.status, rsp.granted};
endmodule

### rtl/core/ffa_front.sv
`timescale 1ns / 1ps
module ffa_front import ffa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic        s_tuser_i,
  input  logic [63:0] s_tdata_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output req_t        q_req_o
);
  localparam int unsigned PtrW = $clog2(QDepth);
  req_t              mem_q [QDepth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              push, pop;
  req_t              in_req;

  // classify beat: opcode from tuser, start then size from tdata
  always_comb begin
    in_req.op    = op_e'(s_tuser_i);
    in_req.start = s_tdata_i[31:0];
    in_req.size  = s_tdata_i[63:32];
  end

  assign s_tready_o = (cnt_q != (PtrW+1)'(QDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_req_o    = mem_q[rd_q];
  assign push = s_tvalid_i && s_tready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    wr_d  = push ? ((wr_q == PtrW'(QDepth-1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop  ? ((rd_q == PtrW'(QDepth-1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_req;
  end

  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= (PtrW+1)'(QDepth);
  endproperty
  assert property (p_no_overflow) else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("count slip");
endmodule

### rtl/core/ffa_back.sv
`timescale 1ns / 1ps
module ffa_back import ffa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_valid_i,
  output logic  q_ready_o,
  input  req_t  q_req_i,
  output logic  r_valid_o,
  input  logic  r_ready_i,
  output rsp_t  r_rsp_o
);
  typedef enum logic [3:0] {
    StIdle, StScanRd, StScanChk, StAlloc, StRelDec, StRelA, StRelMerge,
    StShDnRd, StShDnWr, StShUpRd, StShUpWr, StIns, StOut
  } state_e;

  state_e          state_q;
  req_t            req_q;
  logic [31:0]     starts_mem [TableEntries];
  logic [31:0]     lens_mem   [TableEntries];
  logic [CntW-1:0] held_q, peak_q, k_q, pos_q;
  logic [31:0]     free_q, lostc_q, lostb_q, granted_q, rs_q, rl_q;
  logic [31:0]     ps_q, pl_q;
  logic            status_q, have_prev_q, rdv_q;
  logic [IdxW-1:0] ra;
  logic            re, we;
  logic [IdxW-1:0] wa;
  logic [31:0]     ws, wl;
  logic [31:0]     merge_len_q;

  // single read port, registered data
  always_ff @(posedge clk_i) begin
    if (re) begin
      rs_q <= starts_mem[ra];
      rl_q <= lens_mem[ra];
    end
    if (we) begin
      starts_mem[wa] <= ws;
      lens_mem[wa]   <= wl;
    end
  end

  assign q_ready_o = (state_q == StIdle);
  assign r_valid_o = (state_q == StOut);
  always_comb begin
    r_rsp_o.granted      = granted_q;
    r_rsp_o.status       = status_q;
    r_rsp_o.free_total   = free_q;
    r_rsp_o.entry_count  = cnt_out(held_q);
    r_rsp_o.peak_entries = cnt_out(peak_q);
    r_rsp_o.lost_count   = lostc_q;
    r_rsp_o.lost_bytes   = lostb_q;
  end

  always_comb begin
    re = 1'b0; ra = k_q[IdxW-1:0];
    we = 1'b0; wa = k_q[IdxW-1:0]; ws = rs_q; wl = rl_q;
    unique case (state_q)
      StScanRd, StShDnRd: re = 1'b1;
      StShUpRd: begin re = 1'b1; ra = IdxW'(k_q - 1'b1); end
      StAlloc: begin
        we = 1'b1; ws = rs_q + req_q.size; wl = rl_q - req_q.size;
      end
      StRelA: begin
        we = 1'b1; wa = IdxW'(pos_q - 1'b1); ws = ps_q;
        wl = pl_q + req_q.size;
      end
      StRelMerge: begin
        we = 1'b1; wa = IdxW'(pos_q - 1'b1); ws = ps_q; wl = merge_len_q;
      end
      StShDnWr: begin we = 1'b1; wa = IdxW'(k_q - 1'b1); end
      StShUpWr: we = 1'b1;
      StIns: begin
        we = 1'b1; wa = pos_q[IdxW-1:0]; ws = req_q.start;
        wl = (rdv_q) ? rl_q + req_q.size : req_q.size;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; held_q <= '0; peak_q <= '0; free_q <= '0;
      lostc_q <= '0; lostb_q <= '0; k_q <= '0; pos_q <= '0;
      status_q <= 1'b0; granted_q <= '0; have_prev_q <= 1'b0; rdv_q <= 1'b0;
      req_q <= '0; ps_q <= '0; pl_q <= '0; merge_len_q <= '0;
    end else begin
      unique case (state_q)
        StIdle: if (q_valid_i) begin
          req_q <= q_req_i; k_q <= '0; have_prev_q <= 1'b0;
          granted_q <= '0; status_q <= 1'b0; rdv_q <= 1'b0;
          state_q <= (held_q == '0) ? StRelDec : StScanRd;
          if (held_q == '0 && q_req_i.op == OpAlloc) begin
            status_q <= 1'b1; state_q <= StOut;
          end
        end
        StScanRd: state_q <= StScanChk;
        StScanChk: begin
          if (req_q.op == OpAlloc) begin
            if (rl_q >= req_q.size) state_q <= StAlloc;
            else if (k_q + 1'b1 == held_q) begin
              status_q <= 1'b1; state_q <= StOut;
            end else begin k_q <= k_q + 1'b1; state_q <= StScanRd; end
          end else if (rs_q > req_q.start) begin
            state_q <= StRelDec; rdv_q <= 1'b1;
          end else begin
            have_prev_q <= 1'b1; ps_q <= rs_q; pl_q <= rl_q;
            k_q <= k_q + 1'b1;
            state_q <= (k_q + 1'b1 == held_q) ? StRelDec : StScanRd;
          end
        end
        StAlloc: begin
          granted_q <= rs_q; free_q <= free_q - req_q.size;
          if (rl_q == req_q.size) begin
            held_q <= held_q - 1'b1; k_q <= k_q + 1'b1;
            state_q <= (k_q + 1'b1 < held_q) ? StShDnRd : StOut;
          end else state_q <= StOut;
        end
        StRelDec: begin
          pos_q <= k_q;
          if (have_prev_q && (ps_q + pl_q == req_q.start)) begin
            free_q <= free_q + req_q.size;
            if (rdv_q && (req_q.start + req_q.size == rs_q)) begin
              merge_len_q <= pl_q + req_q.size + rl_q;
              state_q <= StRelMerge;
            end else state_q <= StRelA;
          end else if (rdv_q && (req_q.start + req_q.size == rs_q)) begin
            free_q <= free_q + req_q.size; state_q <= StIns;
          end else if (held_q < CntW'(TableEntries)) begin
            free_q <= free_q + req_q.size; rdv_q <= 1'b0;
            held_q <= held_q + 1'b1;
            if (peak_q < held_q + 1'b1) peak_q <= held_q + 1'b1;
            k_q <= held_q;
            state_q <= (held_q > k_q) ? StShUpRd : StIns;
          end else begin
            lostc_q <= lostc_q + 1'b1; lostb_q <= lostb_q + req_q.size;
            status_q <= 1'b1; state_q <= StOut;
          end
        end
        StRelA: state_q <= StOut;
        StRelMerge: begin
          held_q <= held_q - 1'b1; k_q <= pos_q + 1'b1;
          state_q <= (pos_q + 1'b1 < held_q) ? StShDnRd : StOut;
        end
        StShDnRd: state_q <= StShDnWr;
        StShDnWr: begin
          k_q <= k_q + 1'b1;
          state_q <= (k_q < held_q) ? StShDnRd : StOut;
        end
        StShUpRd: state_q <= StShUpWr;
        StShUpWr: begin
          k_q <= k_q - 1'b1;
          state_q <= (k_q - 1'b1 > pos_q) ? StShUpRd : StIns;
        end
        StIns: state_q <= StOut;
        StOut: if (r_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CntW'(TableEntries)) else $error("held count over depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q >= held_q || state_q != StIdle) else $error("peak below count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOut && !r_ready_i) |=> state_q == StOut)
    else $error("result dropped");
endmodule
